### sv/sha512_pkg.sv
// Shared types, constants and functions for the SHA-512 message hasher.
// No dependencies; sha512_in_if, sha512_message_hasher and sha512_round use it.
`default_nettype none

package sha512_pkg;

    typedef logic [63:0] word_t;
    typedef logic [7:0][63:0] hash_set_t;
    typedef logic [15:0][63:0] sched_t;

    typedef enum logic [1:0] {
        OP_ABSORB     = 2'd0,
        OP_ABSORB_FIN = 2'd1,
        OP_FINISH     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LENGTH_AT   = 7'd112;
    localparam logic [6:0] LEN_LOW_AT  = 7'd120;
    localparam logic [6:0] LAST_BYTE   = 7'd127;
    localparam logic [6:0] LAST_ROUND  = 7'd79;

    localparam hash_set_t START_HASH = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
        64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t round_k(input logic [6:0] t);
        case (t)
            7'd0:  round_k = 64'h428a2f98d728ae22;
            7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;
            7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;
            7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;
            7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;
            7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;
            7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;
            7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;
            7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;
            7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;
            7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;
            7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;
            7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;
            7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;
            7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;
            7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;
            7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;
            7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;
            7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;
            7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;
            7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;
            7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;
            7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;
            7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;
            7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;
            7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;
            7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;
            7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;
            7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;
            7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;
            7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;
            7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;
            7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;
            7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;
            7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84;
            7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;
            7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;
            7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;
            7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = 64'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

### sv/sha512_in_if.sv
// Message input channel: valid/ready handshake carrying one op and one byte.
// Depends on sha512_pkg for the op type.
`default_nettype none

interface sha512_in_if;
    logic             valid;
    logic             ready;
    sha512_pkg::op_t  op;
    logic [7:0]       data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

### sv/sha512_out_if.sv
// Digest output channel: valid/ready handshake carrying one 64-bit digest word.
// Standalone; no package types needed.
`default_nettype none

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

### sv/sha512_message_hasher.sv
// SHA-512 message hasher: byte-serial intake, padding sequencer, round loop.
// Depends on sha512_pkg, sha512_in_if, sha512_out_if and sha512_round.
//
// Usage: message bytes arrive on the msg channel, one byte per handshake.
// op ABSORB adds a byte, ABSORB_FIN adds a byte and closes the message,
// FINISH closes it without a byte; the unused op code is dropped.
// Bytes shift into a 128-byte block register; the 128th byte starts an
// 80-round compression on the single round unit, one round per cycle,
// followed by a step that folds the result into the hash words.
// Throughput: one byte per cycle while filling; a full block then holds
// msg.ready low through the 80 rounds and the fold. The working variables are
// loaded at the edge that accepts the 128th byte.
// On finish the sequencer shifts in 0x80, zero fill and the 64-bit bit
// count one byte per cycle (one block, or two blocks when more than
// 111 bytes are buffered), compresses, then offers the eight digest words
// on the digest channel, index 0 first. msg.ready stays low until the last
// digest word is taken, so a stalled receiver simply holds the block.
// After the eighth word the hash words, byte count and bit count return to
// their initial values. Reset (rst_n low, asynchronous) does the same and
// leaves the block idle and ready.
`default_nettype none

module sha512_message_hasher (
    input  logic clk,
    input  logic rst_n,
    sha512_in_if.sink    msg,
    sha512_out_if.source digest
);
    import sha512_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;
    logic       first_reg, first_next;
    logic       extra_reg, extra_next;
    logic       last_reg, last_next;
    hash_set_t  hash_reg, hash_next;
    hash_set_t  wv_reg, wv_next;
    sched_t     blk_reg, blk_next;

    hash_set_t  wv_round;
    word_t      w_new;
    logic [7:0] pad_byte;
    logic [7:0] len_byte;

    sha512_round u_round (
        .wv     (wv_reg),
        .w_t    (blk_reg[0]),
        .w_1    (blk_reg[1]),
        .w_9    (blk_reg[9]),
        .w_14   (blk_reg[14]),
        .k_t    (round_k(rnd_reg)),
        .wv_new (wv_round),
        .w_new  (w_new)
    );

    assign len_byte = 8'(bits_reg >> {3'd7 - cnt_reg[2:0], 3'b000});

    always_comb
    begin
        if (first_reg)
            pad_byte = PAD_BYTE;
        else if (!extra_reg && cnt_reg >= LEN_LOW_AT)
            pad_byte = len_byte;
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        extra_next = extra_reg;
        last_next  = last_reg;
        hash_next  = hash_reg;
        wv_next    = wv_reg;
        blk_next   = blk_reg;

        msg.ready          = 1'b0;
        digest.valid       = 1'b0;
        digest.digest_word = hash_reg[idx_reg];
        digest.word_index  = idx_reg;
        digest.last_word   = (idx_reg == 3'd7);

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    case (msg.op)
                        OP_ABSORB, OP_ABSORB_FIN:
                        begin
                            for (int i = 0; i < 15; i++)
                                blk_next[i] = {blk_reg[i][55:0], blk_reg[i+1][63:56]};
                            blk_next[15] = {blk_reg[15][55:0], msg.data_byte};
                            cnt_next  = cnt_reg + 7'd1;
                            bits_next = bits_reg + 64'd8;
                            if (msg.op == OP_ABSORB_FIN)
                            begin
                                fin_next   = 1'b1;
                                first_next = 1'b1;
                                last_next  = 1'b0;
                            end
                            if (cnt_reg == LAST_BYTE)
                            begin
                                wv_next    = hash_reg;
                                rnd_next   = '0;
                                state_next = ST_ROUND;
                            end
                            else if (msg.op == OP_ABSORB_FIN)
                                state_next = ST_PAD;
                        end
                        OP_FINISH:
                        begin
                            fin_next   = 1'b1;
                            first_next = 1'b1;
                            last_next  = 1'b0;
                            state_next = ST_PAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PAD:
            begin
                for (int i = 0; i < 15; i++)
                    blk_next[i] = {blk_reg[i][55:0], blk_reg[i+1][63:56]};
                blk_next[15] = {blk_reg[15][55:0], pad_byte};
                cnt_next   = cnt_reg + 7'd1;
                first_next = 1'b0;
                if (cnt_reg == LAST_BYTE)
                begin
                    // A pad byte in the final slot means the length goes in
                    // one more block.
                    last_next  = first_reg ? 1'b0 : !extra_reg;
                    extra_next = 1'b0;
                    wv_next    = hash_reg;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                end
                else if (first_reg)
                    extra_next = (cnt_reg >= LENGTH_AT);
            end

            ST_ROUND:
            begin
                wv_next = wv_round;
                for (int i = 0; i < 15; i++)
                    blk_next[i] = blk_reg[i+1];
                blk_next[15] = w_new;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end

            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    hash_next[i] = hash_reg[i] + wv_reg[i];
                if (last_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end

            ST_OUT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        hash_next  = START_HASH;
                        cnt_next   = '0;
                        bits_next  = '0;
                        fin_next   = 1'b0;
                        last_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            extra_reg <= 1'b0;
            last_reg  <= 1'b0;
            hash_reg  <= START_HASH;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            extra_reg <= extra_next;
            last_reg  <= last_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        blk_reg <= blk_next;
    end

endmodule

`default_nettype wire

### sv/sha512_round.sv
// One SHA-512 round plus one message schedule step, purely combinational.
// Depends on sha512_pkg for word types and rotate helper.
`default_nettype none

module sha512_round (
    input  sha512_pkg::hash_set_t wv,
    input  sha512_pkg::word_t     w_t,
    input  sha512_pkg::word_t     w_1,
    input  sha512_pkg::word_t     w_9,
    input  sha512_pkg::word_t     w_14,
    input  sha512_pkg::word_t     k_t,
    output sha512_pkg::hash_set_t wv_new,
    output sha512_pkg::word_t     w_new
);
    import sha512_pkg::*;

    word_t a, b, c, d, e, f, g, h;
    word_t big_s0, big_s1, ch, maj, t1, t2, sig0, sig1;

    always_comb
    begin
        a = wv[0]; b = wv[1]; c = wv[2]; d = wv[3];
        e = wv[4]; f = wv[5]; g = wv[6]; h = wv[7];
        big_s1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
        big_s0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
        ch     = (e & f) ^ (~e & g);
        maj    = (a & b) ^ (a & c) ^ (b & c);
        t1     = h + big_s1 + ch + k_t + w_t;
        t2     = big_s0 + maj;
        wv_new[7] = g;
        wv_new[6] = f;
        wv_new[5] = e;
        wv_new[4] = d + t1;
        wv_new[3] = c;
        wv_new[2] = b;
        wv_new[1] = a;
        wv_new[0] = t1 + t2;
        // The window holds w[t..t+15]; this produces w[t+16].
        sig1  = rotr(w_14, 19) ^ rotr(w_14, 61) ^ (w_14 >> 6);
        sig0  = rotr(w_1, 1) ^ rotr(w_1, 8) ^ (w_1 >> 7);
        w_new = sig1 + w_9 + sig0 + w_t;
    end

endmodule

`default_nettype wire
